// File: hw/rtl/fs4_pkg.sv
// Shared constants, types and the half-band tap table for the fs/4 downconverter.
// Used by the controller, datapath and top level; no dependencies.
package fs4_pkg;
  localparam int NTAPS = 41;
  localparam int SAMPLE_WIDTH = 16;
  localparam int TAP_FRAC_BITS = 15;
  localparam int IDXW = $clog2(NTAPS);
  localparam int FILLW = $clog2(NTAPS + 2);
  localparam int ACCW = 48;

  typedef logic signed [15:0] tap_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mac;
    logic capture;
    logic [IDXW-1:0] idx;
  } dp_cmd_t;

  function automatic tap_t std_tap(input int k);
    tap_t t;
    begin
      unique case (k)
        1, 39: t = -16'sd34;
        3, 37: t = 16'sd82;
        5, 35: t = -16'sd160;
        7, 33: t = 16'sd280;
        9, 31: t = -16'sd458;
        11, 29: t = 16'sd721;
        13, 27: t = -16'sd1125;
        15, 25: t = 16'sd1811;
        17, 23: t = -16'sd3306;
        19, 21: t = 16'sd10372;
        20: t = 16'sd16384;
        default: t = 16'sd0;
      endcase
      return t;
    end
  endfunction

  function automatic tap_t tap_coef(input int k);
    int sh;
    int v;
    int m;
    begin
      sh = 15 - TAP_FRAC_BITS;
      v = int'(std_tap(k));
      if (sh == 0) return tap_t'(v);
      m = (v < 0) ? -v : v;
      m = (m + (1 << (sh - 1))) >>> sh;
      return tap_t'((v < 0) ? -m : m);
    end
  endfunction
endpackage

// File: hw/rtl/fs4_ctrl.sv
// Sequencer for the fs/4 downconverter: accepts words, steps the MAC and hands off results.
// Depends on fs4_pkg.
module fs4_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic block_start,
  output logic out_valid,
  input  logic out_ready,
  output fs4_pkg::dp_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [fs4_pkg::FILLW-1:0] fill_r, fill_nxt, fill_inc;
  logic [fs4_pkg::IDXW-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fill_inc = (block_start ? '0 : fill_r) + 1'b1;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    cmd.idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          fill_nxt = (fill_inc > fs4_pkg::FILLW'(fs4_pkg::NTAPS + 1)) ?
                     fs4_pkg::FILLW'(fs4_pkg::NTAPS) : fill_inc;
          if (fill_nxt == fs4_pkg::FILLW'(fs4_pkg::NTAPS)) begin
            cmd.clear = 1'b1;
            idx_nxt = '0;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (idx_r == fs4_pkg::IDXW'(fs4_pkg::NTAPS - 1)) state_nxt = S_OUT;
        else idx_nxt = idx_r + 1'b1;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= fs4_pkg::FILLW'(fs4_pkg::NTAPS + 1)) else $error("fill count out of range");
  a_mac_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && idx_r == fs4_pkg::IDXW'(fs4_pkg::NTAPS - 1)) |=> state_r == S_OUT)
    else $error("MAC did not end in output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("output word dropped");
  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_valid_r || out_ready)) else $error("output word overwritten");
`endif
endmodule

// File: hw/rtl/fs4_datapath.sv
// Mixer, I/Q delay lines and shared multiply-accumulate for the fs/4 downconverter.
// Depends on fs4_pkg.
module fs4_datapath (
  input  logic clk,
  input  logic rst_n,
  input  fs4_pkg::dp_cmd_t cmd,
  input  logic signed [15:0] sample,
  input  logic block_start,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q
);
  localparam int SW = fs4_pkg::SAMPLE_WIDTH;
  localparam int N = fs4_pkg::NTAPS;
  localparam int AW = fs4_pkg::ACCW;

  logic signed [SW-1:0] dre_r [N];
  logic signed [SW-1:0] dim_r [N];
  logic [1:0] phase_r;
  logic [1:0] ph;
  logic signed [SW-1:0] s, neg, re, im;
  logic signed [AW-1:0] acc_i_r, acc_q_r;
  logic signed [15:0] tap;
  logic signed [SW-1:0] xr, xi;
  logic signed [15:0] out_i_r, out_q_r;

  function automatic logic signed [15:0] scale(input logic signed [AW-1:0] a);
    logic [AW-1:0] mag;
    begin
      mag = a[AW-1] ? (~a + 1'b1) : a;
      mag = mag >> fs4_pkg::TAP_FRAC_BITS;
      if (a[AW-1]) return (mag > AW'(32768)) ? -16'sd32768 : 16'(-mag);
      return (mag > AW'(32767)) ? 16'sd32767 : 16'(mag);
    end
  endfunction

  assign s = sample[SW-1:0];
  assign ph = block_start ? 2'd0 : phase_r;
  assign neg = (s == {1'b1, {(SW-1){1'b0}}}) ? {1'b0, {(SW-1){1'b1}}} : -s;

  always_comb begin
    re = '0;
    im = '0;
    unique case (ph)
      2'd0: re = s;
      2'd1: im = s;
      2'd2: re = neg;
      default: im = neg;
    endcase
  end

  assign tap = fs4_pkg::tap_coef(int'(cmd.idx));
  assign xr = dre_r[0];
  assign xi = dim_r[0];

  // The MAC pass rotates the window once per tap, so a full pass restores it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      for (int k = 0; k < N; k++) begin
        dre_r[k] <= '0;
        dim_r[k] <= '0;
      end
    end else if (cmd.load) begin
      phase_r <= ph + 2'd1;
      for (int k = 0; k < N - 1; k++) begin
        dre_r[k] <= dre_r[k+1];
        dim_r[k] <= dim_r[k+1];
      end
      dre_r[N-1] <= re;
      dim_r[N-1] <= im;
    end else if (cmd.mac) begin
      for (int k = 0; k < N - 1; k++) begin
        dre_r[k] <= dre_r[k+1];
        dim_r[k] <= dim_r[k+1];
      end
      dre_r[N-1] <= dre_r[0];
      dim_r[N-1] <= dim_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (cmd.mac) begin
      acc_i_r <= acc_i_r + AW'(tap * xr);
      acc_q_r <= acc_q_r + AW'(tap * xi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_i_r <= '0;
      out_q_r <= '0;
    end else if (cmd.capture) begin
      out_i_r <= scale(acc_i_r);
      out_q_r <= scale(acc_q_r);
    end
  end

  assign out_i = out_i_r;
  assign out_q = out_q_r;
endmodule

// File: hw/rtl/fs4_mixer_halfband_decimator.sv
// Top level of the fs/4 mixer and half-band decimate-by-2 filter.
// Depends on fs4_pkg, fs4_ctrl and fs4_datapath.
// Each accepted word is mixed by 1, j, -1, -j and shifted into 41-deep I and Q
// delay lines. A word that completes an output pair starts a serial MAC pass
// over all taps on one shared I/Q multiplier pair, after which the result moves
// into an output register once that register is free. Words that yield no
// result need no MAC pass. No input is accepted during the MAC pass; input is
// accepted again once the new result has been stored, which waits only while
// the previous result still sits in the output register.
module fs4_mixer_halfband_decimator (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] in_sample,
  input  logic in_block_start,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] out_out_i,
  output logic signed [15:0] out_out_q
);
  fs4_pkg::dp_cmd_t cmd;

  fs4_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .block_start(in_block_start), .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd)
  );

  fs4_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sample(in_sample),
    .block_start(in_block_start), .out_i(out_out_i), .out_q(out_out_q)
  );
endmodule
